// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, idle during reset.
`define RMX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rmx assertion failed");

// Assertion that only looks while a result is offered.
`define RMX_ASSERT_OUT(lbl, prop) \
  `RMX_ASSERT(lbl, out_valid_o |-> (prop))

`endif

// ===== rtl/rmx_pkg.sv =====
`timescale 1ns / 1ps

package rmx_pkg;

  localparam int MutexCount = 16;
  localparam int QueueDepth = 16;

  localparam int SlotW    = (MutexCount > 1) ? $clog2(MutexCount) : 1;
  localparam int PosW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW     = $clog2(QueueDepth + 1);
  localparam int AddrW    = SlotW + PosW;
  localparam int RamDepth = 1 << AddrW;

  typedef enum logic [2:0] {
    REQ_CREATE  = 3'd0,
    REQ_DESTROY = 3'd1,
    REQ_LOCK    = 3'd2,
    REQ_TRYLOCK = 3'd3,
    REQ_UNLOCK  = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_WOULD_BLOCK = 3'd2,
    ST_NOT_OWNER   = 3'd3,
    ST_QUEUED      = 3'd4,
    ST_NO_SLOT     = 3'd5,
    ST_QUEUE_FULL  = 3'd6,
    ST_OVERFLOW    = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ENQ_RD,
    S_ENQ_CMP,
    S_ENQ_INS,
    S_DQ_RD,
    S_DQ_MV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [31:0] deadline;
  } entry_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  slot_index;
    logic        woken_valid;
    logic [7:0]  woken_task;
    logic        is_owner;
    logic [4:0]  waiter_total;
  } res_t;

endpackage

// ===== rtl/rmx_wait_ram.sv =====
`timescale 1ns / 1ps

module rmx_wait_ram (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [rmx_pkg::AddrW-1:0] waddr_i,
  input  rmx_pkg::entry_t       wdata_i,
  input  logic [rmx_pkg::AddrW-1:0] raddr_i,
  output rmx_pkg::entry_t       rdata_o
);
  import rmx_pkg::*;

  entry_t mem_q [RamDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/rmx_seq.sv =====
`timescale 1ns / 1ps

module rmx_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        req_type_i,
  input  logic [3:0]        mutex_index_i,
  input  logic              task_present_i,
  input  logic [7:0]        task_id_i,
  input  logic [31:0]       task_deadline_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output rmx_pkg::res_t     res_o,
  output logic              we_o,
  output logic [rmx_pkg::AddrW-1:0] waddr_o,
  output rmx_pkg::entry_t   wdata_o,
  output logic [rmx_pkg::AddrW-1:0] raddr_o,
  input  rmx_pkg::entry_t   rdata_i
);
  import rmx_pkg::*;

  state_e state_q, state_d;

  logic [2:0]  req_q;
  logic [3:0]  idx_q;
  logic        pres_q;
  logic [7:0]  task_q;
  logic [31:0] dl_q;

  logic            alloc_q [MutexCount];
  logic            alloc_d [MutexCount];
  logic            held_q  [MutexCount];
  logic            held_d  [MutexCount];
  logic [7:0]      owner_q [MutexCount];
  logic [7:0]      owner_d [MutexCount];
  logic [7:0]      depth_q [MutexCount];
  logic [7:0]      depth_d [MutexCount];
  logic [CntW-1:0] cnt_q   [MutexCount];
  logic [CntW-1:0] cnt_d   [MutexCount];

  status_e         status_q, status_d;
  logic [3:0]      slot_q, slot_d;
  logic            report_q, report_d;
  logic            wv_q, wv_d;
  logic [7:0]      wt_q, wt_d;
  logic [PosW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] n_q, n_d;

  logic [SlotW-1:0] sel;
  logic             in_range;
  logic             valid_slot;
  logic             owned;
  logic             free_found;
  logic [SlotW-1:0] free_idx;
  entry_t           new_entry;

  assign sel        = SlotW'(idx_q);
  assign in_range   = int'(idx_q) < MutexCount;
  assign valid_slot = in_range && alloc_q[sel];
  assign owned      = held_q[sel] && (owner_q[sel] == task_q);
  assign new_entry  = '{task_id: task_q, deadline: dl_q};
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MutexCount - 1; i >= 0; i--) begin
      if (!alloc_q[i]) begin
        free_found = 1'b1;
        free_idx   = SlotW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q  <= req_type_i;
      idx_q  <= mutex_index_i;
      pres_q <= task_present_i;
      task_q <= task_id_i;
      dl_q   <= task_deadline_i;
    end
  end

  always_comb begin
    state_d  = state_q;
    alloc_d  = alloc_q;
    held_d   = held_q;
    owner_d  = owner_q;
    depth_d  = depth_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    slot_d   = slot_q;
    report_d = report_q;
    wv_d     = wv_q;
    wt_d     = wt_q;
    ptr_d    = ptr_q;
    n_d      = n_q;
    we_o     = 1'b0;
    waddr_o  = {sel, ptr_q};
    wdata_o  = new_entry;
    raddr_o  = {sel, ptr_q};
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d  = S_DONE;
        status_d = ST_INVALID;
        slot_d   = idx_q;
        report_d = 1'b0;
        wv_d     = 1'b0;
        wt_d     = '0;
        if (req_q == REQ_CREATE) begin
          slot_d = '0;
          if (free_found) begin
            status_d          = ST_OK;
            slot_d            = 4'(free_idx);
            alloc_d[free_idx] = 1'b1;
            held_d[free_idx]  = 1'b0;
            owner_d[free_idx] = '0;
            depth_d[free_idx] = '0;
            cnt_d[free_idx]   = '0;
          end else begin
            status_d = ST_NO_SLOT;
          end
        end else if (req_q <= REQ_UNLOCK && valid_slot) begin
          report_d = 1'b1;
          if (req_q == REQ_DESTROY) begin
            if (!held_q[sel] && cnt_q[sel] == '0) begin
              status_d     = ST_OK;
              alloc_d[sel] = 1'b0;
              held_d[sel]  = 1'b0;
              owner_d[sel] = '0;
              depth_d[sel] = '0;
              cnt_d[sel]   = '0;
            end
          end else if (!pres_q) begin
            status_d = ST_INVALID;
          end else if (req_q == REQ_LOCK || req_q == REQ_TRYLOCK) begin
            if (owned) begin
              if (depth_q[sel] == 8'hFF) begin
                status_d = ST_OVERFLOW;
              end else begin
                status_d     = ST_OK;
                depth_d[sel] = depth_q[sel] + 8'd1;
              end
            end else if (!held_q[sel]) begin
              status_d     = ST_OK;
              held_d[sel]  = 1'b1;
              owner_d[sel] = task_q;
              depth_d[sel] = 8'd1;
            end else if (req_q == REQ_TRYLOCK) begin
              status_d = ST_WOULD_BLOCK;
            end else if (int'(cnt_q[sel]) >= QueueDepth) begin
              status_d = ST_QUEUE_FULL;
            end else begin
              status_d   = ST_QUEUED;
              cnt_d[sel] = cnt_q[sel] + CntW'(1);
              n_d        = cnt_q[sel];
              if (cnt_q[sel] == '0) begin
                ptr_d   = '0;
                state_d = S_ENQ_INS;
              end else begin
                ptr_d   = PosW'(cnt_q[sel] - CntW'(1));
                state_d = S_ENQ_RD;
              end
            end
          end else begin
            if (!owned) begin
              status_d = ST_NOT_OWNER;
            end else if (depth_q[sel] > 8'd1) begin
              status_d     = ST_OK;
              depth_d[sel] = depth_q[sel] - 8'd1;
            end else if (cnt_q[sel] != '0) begin
              status_d     = ST_OK;
              depth_d[sel] = 8'd1;
              cnt_d[sel]   = cnt_q[sel] - CntW'(1);
              n_d          = cnt_q[sel];
              ptr_d        = '0;
              state_d      = S_DQ_RD;
            end else begin
              status_d     = ST_OK;
              held_d[sel]  = 1'b0;
              owner_d[sel] = '0;
              depth_d[sel] = '0;
            end
          end
        end
      end
      S_ENQ_RD: begin
        state_d = S_ENQ_CMP;
      end
      S_ENQ_CMP: begin
        we_o    = 1'b1;
        waddr_o = {sel, PosW'(ptr_q + PosW'(1))};
        if (rdata_i.deadline > dl_q) begin
          wdata_o = rdata_i;
          if (ptr_q == '0) begin
            state_d = S_ENQ_INS;
          end else begin
            ptr_d   = ptr_q - PosW'(1);
            state_d = S_ENQ_RD;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_ENQ_INS: begin
        we_o    = 1'b1;
        state_d = S_DONE;
      end
      S_DQ_RD: begin
        state_d = S_DQ_MV;
      end
      S_DQ_MV: begin
        if (ptr_q == '0) begin
          wv_d         = 1'b1;
          wt_d         = rdata_i.task_id;
          owner_d[sel] = rdata_i.task_id;
        end else begin
          we_o    = 1'b1;
          waddr_o = {sel, PosW'(ptr_q - PosW'(1))};
          wdata_o = rdata_i;
        end
        if ((CntW'(ptr_q) + CntW'(1)) < n_q) begin
          ptr_d   = ptr_q + PosW'(1);
          state_d = S_DQ_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_o.status       = status_q;
    res_o.slot_index   = slot_q;
    res_o.woken_valid  = wv_q;
    res_o.woken_task   = wt_q;
    res_o.is_owner     = report_q && pres_q && alloc_q[sel] && owned;
    res_o.waiter_total = report_q ? 5'(cnt_q[sel]) : 5'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < MutexCount; i++) begin
        alloc_q[i] <= 1'b0;
        held_q[i]  <= 1'b0;
        owner_q[i] <= '0;
        depth_q[i] <= '0;
        cnt_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      alloc_q <= alloc_d;
      held_q  <= held_d;
      owner_q <= owner_d;
      depth_q <= depth_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    slot_q   <= slot_d;
    report_q <= report_d;
    wv_q     <= wv_d;
    wt_q     <= wt_d;
    ptr_q    <= ptr_d;
    n_q      <= n_d;
  end

endmodule

// ===== rtl/recursive_mutex_edf_wait_queue.sv =====
`timescale 1ns / 1ps

// Pool of recursive mutexes with deadline-ordered wait queues. One request is
// handled at a time: in_ready_o is high only while the sequencer is idle.
// Create, destroy, trylock, recursive lock and plain unlock pass from the execute
// state straight to the done state. A queued lock walks the waiter RAM from the
// tail through one deadline comparator, reading each waiter and moving it up one
// place while its deadline is later; the walk stops at the head or at a waiter
// with an earlier or equal deadline. An unlock that hands over reads every waiter
// and shifts the rest toward the head through the RAM's one read and one write
// port. A finished result sits in the output register, and the next request is
// taken while it waits there.
module recursive_mutex_edf_wait_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [3:0]  mutex_index_i,
  input  logic        task_present_i,
  input  logic [7:0]  task_id_i,
  input  logic [31:0] task_deadline_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_index_o,
  output logic        woken_valid_o,
  output logic [7:0]  woken_task_o,
  output logic        is_owner_o,
  output logic [4:0]  waiter_total_o
);
  import rmx_pkg::*;

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  res_t             out_q;
  logic             out_valid_q;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;
  entry_t           wdata;
  entry_t           rdata;

  assign res_ready = !out_valid_q || out_ready_i;

  rmx_seq u_seq (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .req_type_i,
    .mutex_index_i,
    .task_present_i,
    .task_id_i,
    .task_deadline_i,
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  rmx_wait_ram u_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign slot_index_o   = out_q.slot_index;
  assign woken_valid_o  = out_q.woken_valid;
  assign woken_task_o   = out_q.woken_task;
  assign is_owner_o     = out_q.is_owner;
  assign waiter_total_o = out_q.waiter_total;

endmodule

// ===== rtl/rmx_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [3:0]  slot_index_o,
  input logic        woken_valid_o,
  input logic        is_owner_o,
  input logic [4:0]  waiter_total_o
);
  import rmx_pkg::*;

  `RMX_ASSERT(a_busy_after_transfer, in_valid_i && in_ready_o |=> !in_ready_o)
  `RMX_ASSERT_OUT(a_woken_ok, !woken_valid_o || status_o == ST_OK)
  `RMX_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
  `RMX_ASSERT_OUT(a_no_slot_zero, status_o != ST_NO_SLOT || slot_index_o == 4'd0)
  `RMX_ASSERT_OUT(a_total_bound, int'(waiter_total_o) <= QueueDepth)

endmodule

bind recursive_mutex_edf_wait_queue rmx_checker u_rmx_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .status_o,
  .slot_index_o,
  .woken_valid_o,
  .is_owner_o,
  .waiter_total_o
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import rmx_pkg::*;

  localparam int NumSlots = 16;
  localparam int NumWait = 16;
  localparam int WatchdogLimit = 20000;

  typedef struct {
    logic [2:0] status;
    logic [3:0] slot;
    logic       wvalid;
    logic [7:0] wtask;
    logic       owner;
    logic [4:0] wtotal;
  } mutex_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  req_type_i = '0;
  logic [3:0]  mutex_index_i = '0;
  logic        task_present_i = 1'b0;
  logic [7:0]  task_id_i = '0;
  logic [31:0] task_deadline_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  slot_index_o;
  logic        woken_valid_o;
  logic [7:0]  woken_task_o;
  logic        is_owner_o;
  logic [4:0]  waiter_total_o;

  recursive_mutex_edf_wait_queue DUT (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // shadow state of the mutex pool
  logic        mx_alloc [NumSlots];
  logic        mx_held [NumSlots];
  logic [7:0]  mx_owner [NumSlots];
  logic [7:0]  mx_depth [NumSlots];
  int          mx_nwait [NumSlots];
  logic [7:0]  wq_tid [NumSlots][NumWait];
  logic [31:0] wq_dl [NumSlots][NumWait];

  mutex_result_t expected_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  int handovers = 0;
  int queued_locks = 0;
  int n_sent = 0;

  function automatic mutex_result_t apply_request(logic [2:0] rq, logic [3:0] idx,
                                                  logic pres, logic [7:0] tid,
                                                  logic [31:0] dl);
    mutex_result_t r;
    int pos;
    int n;
    logic report;
    r = '{ST_INVALID, idx, 1'b0, 8'd0, 1'b0, 5'd0};
    report = 1'b0;
    if (rq == REQ_CREATE) begin
      r.status = ST_NO_SLOT;
      r.slot = '0;
      for (int s = 0; s < NumSlots; s++) begin
        if (!mx_alloc[s]) begin
          mx_alloc[s] = 1'b1; mx_held[s] = 1'b0; mx_owner[s] = '0;
          mx_depth[s] = '0; mx_nwait[s] = 0;
          r.slot = s[3:0];
          r.status = ST_OK;
          break;
        end
      end
    end else if (rq <= REQ_UNLOCK && mx_alloc[idx]) begin
      report = 1'b1;
      if (rq == REQ_DESTROY) begin
        if (!mx_held[idx] && mx_nwait[idx] == 0) begin
          mx_alloc[idx] = 1'b0; mx_owner[idx] = '0; mx_depth[idx] = '0;
          r.status = ST_OK;
        end
      end else if (!pres) begin
        r.status = ST_INVALID;
      end else if (rq == REQ_LOCK || rq == REQ_TRYLOCK) begin
        if (mx_held[idx] && mx_owner[idx] == tid) begin
          if (mx_depth[idx] == 8'd255) r.status = ST_OVERFLOW;
          else begin
            mx_depth[idx]++;
            r.status = ST_OK;
          end
        end else if (!mx_held[idx]) begin
          mx_held[idx] = 1'b1; mx_owner[idx] = tid; mx_depth[idx] = 8'd1;
          r.status = ST_OK;
        end else if (rq == REQ_TRYLOCK) begin
          r.status = ST_WOULD_BLOCK;
        end else if (mx_nwait[idx] >= NumWait) begin
          r.status = ST_QUEUE_FULL;
        end else begin
          n = mx_nwait[idx];
          pos = 0;
          while (pos < n && wq_dl[idx][pos] <= dl) pos++;
          for (int i = n; i > pos; i--) begin
            wq_tid[idx][i] = wq_tid[idx][i-1];
            wq_dl[idx][i] = wq_dl[idx][i-1];
          end
          wq_tid[idx][pos] = tid;
          wq_dl[idx][pos] = dl;
          mx_nwait[idx] = n + 1;
          r.status = ST_QUEUED;
          queued_locks++;
        end
      end else begin
        if (!mx_held[idx] || mx_owner[idx] != tid) begin
          r.status = ST_NOT_OWNER;
        end else if (mx_depth[idx] > 1) begin
          mx_depth[idx]--;
          r.status = ST_OK;
        end else if (mx_nwait[idx] > 0) begin
          r.wvalid = 1'b1;
          r.wtask = wq_tid[idx][0];
          for (int i = 1; i < mx_nwait[idx]; i++) begin
            wq_tid[idx][i-1] = wq_tid[idx][i];
            wq_dl[idx][i-1] = wq_dl[idx][i];
          end
          mx_nwait[idx]--;
          mx_owner[idx] = r.wtask;
          mx_depth[idx] = 8'd1;
          r.status = ST_OK;
          handovers++;
        end else begin
          mx_held[idx] = 1'b0; mx_owner[idx] = '0; mx_depth[idx] = '0;
          r.status = ST_OK;
        end
      end
    end
    if (report) begin
      r.owner = pres && mx_alloc[idx] && mx_held[idx] && mx_owner[idx] == tid;
      r.wtotal = mx_nwait[idx][4:0];
    end
    return r;
  endfunction

  task automatic send_request(logic [2:0] rq, logic [3:0] idx, logic pres,
                              logic [7:0] tid, logic [31:0] dl);
    if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rq;
    mutex_index_i <= idx;
    task_present_i <= pres;
    task_id_i <= tid;
    task_deadline_i <= dl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.push_back(apply_request(rq, idx, pres, tid, dl));
    n_sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    mutex_result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); errors++;
        end
        if (slot_index_o !== e.slot) begin
          $error("slot_index exp %0d got %0d", e.slot, slot_index_o); errors++;
        end
        if (woken_valid_o !== e.wvalid) begin
          $error("woken_valid exp %0d got %0d", e.wvalid, woken_valid_o); errors++;
        end
        if (woken_task_o !== e.wtask) begin
          $error("woken_task exp %0d got %0d", e.wtask, woken_task_o); errors++;
        end
        if (is_owner_o !== e.owner) begin
          $error("is_owner exp %0d got %0d", e.owner, is_owner_o); errors++;
        end
        if (waiter_total_o !== e.wtotal) begin
          $error("waiter_total exp %0d got %0d", e.wtotal, waiter_total_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else if (++idle_cycles >= WatchdogLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic test_directed;
    for (int i = 0; i < 17; i++) send_request(REQ_CREATE, 4'd0, 1'b1, 8'd0, 32'd0);
    send_request(REQ_DESTROY, 4'd15, 1'b1, 8'd0, 32'd0);
    send_request(REQ_LOCK, 4'd15, 1'b1, 8'd1, 32'd0);
    send_request(3'd5, 4'd3, 1'b1, 8'd1, 32'd0);
    send_request(3'd7, 4'd3, 1'b0, 8'hff, 32'hffff_ffff);
    send_request(REQ_LOCK, 4'd0, 1'b0, 8'hff, 32'd0);
    send_request(REQ_LOCK, 4'd0, 1'b1, 8'hff, 32'd0);
    send_request(REQ_TRYLOCK, 4'd0, 1'b1, 8'h00, 32'd0);
    send_request(REQ_LOCK, 4'd0, 1'b1, 8'h10, 32'hffff_ffff);
    send_request(REQ_LOCK, 4'd0, 1'b1, 8'h11, 32'd5);
    send_request(REQ_LOCK, 4'd0, 1'b1, 8'h12, 32'd5);
    send_request(REQ_LOCK, 4'd0, 1'b1, 8'h10, 32'd0);
    send_request(REQ_DESTROY, 4'd0, 1'b1, 8'hff, 32'd0);
    send_request(REQ_UNLOCK, 4'd0, 1'b1, 8'h01, 32'd0);
    send_request(REQ_UNLOCK, 4'd0, 1'b0, 8'hff, 32'd0);
    for (int i = 0; i < 5; i++) send_request(REQ_UNLOCK, 4'd0, 1'b1, mx_owner[0], 32'd0);
    send_request(REQ_DESTROY, 4'd0, 1'b1, 8'd0, 32'd0);
    drain();
  endtask

  // drive one slot to the recursion limit and fill its queue
  task automatic test_limits;
    for (int i = 0; i < 256; i++) send_request(REQ_TRYLOCK, 4'd5, 1'b1, 8'h55, 32'd0);
    send_request(REQ_LOCK, 4'd5, 1'b1, 8'h55, 32'd0);
    for (int i = 0; i < 17; i++)
      send_request(REQ_LOCK, 4'd5, 1'b1, $urandom_range(255, 0), $urandom_range(3, 0));
    for (int i = 0; i < 300; i++) send_request(REQ_UNLOCK, 4'd5, 1'b1, mx_owner[5], 32'd0);
    drain();
  endtask

  task automatic test_random(int count);
    logic [2:0] rq;
    logic [3:0] idx;
    logic [7:0] tid;
    logic [31:0] dl;
    for (int i = 0; i < count; i++) begin
      idx = $urandom_range(3, 0);
      if ($urandom_range(9, 0) == 0) idx = $urandom_range(15, 0);
      case ($urandom_range(9, 0))
        0: rq = REQ_CREATE;
        1: rq = ($urandom_range(1, 0)) ? REQ_DESTROY : $urandom_range(7, 5);
        2, 3, 4: rq = REQ_LOCK;
        5: rq = REQ_TRYLOCK;
        default: rq = REQ_UNLOCK;
      endcase
      tid = $urandom_range(7, 0);
      if (rq == REQ_UNLOCK && $urandom_range(3, 0) != 0) tid = mx_owner[idx];
      if ($urandom_range(15, 0) == 0) tid = $urandom_range(255, 0);
      dl = ($urandom_range(1, 0)) ? $urandom_range(7, 0) : $urandom();
      send_request(rq, idx, $urandom_range(19, 0) != 0, tid, dl);
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limits();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(250);
    send_idle_pct = 59; recv_stall_pct = 0;  test_random(200);
    send_idle_pct = 0;  recv_stall_pct = 59; test_random(200);
    send_idle_pct = 16; recv_stall_pct = 16; test_random(250);
    $display("Sent %0d requests: %0d queued locks, %0d hand-overs,", n_sent,
             queued_locks, handovers);
    $display("pool exhaustion, recursion overflow and full queues included.");
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
